[rtl/core/clif_pkg.sv]
// Shared types and constants for the conductance LIF neuron update block.
// No dependencies; every module under rtl/core imports this package.
package clif_pkg;

	// Operation codes of an input transaction
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// Configuration register indexes (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_LEAK_RATE       = 3'd0,
		REG_LEAK_REVERSAL   = 3'd1,
		REG_EXC_REVERSAL    = 3'd2,
		REG_INH_REVERSAL    = 3'd3,
		REG_EXC_DECAY       = 3'd4,
		REG_INH_DECAY       = 3'd5,
		REG_SPIKE_THRESHOLD = 3'd6,
		REG_RESET_POTENTIAL = 3'd7
	} reg_idx_t;

	// Register reset values
	localparam logic [15:0] RST_LEAK_RATE       = 16'd655;
	localparam logic [15:0] RST_LEAK_REVERSAL   = 16'hC400;  // -15360
	localparam logic [15:0] RST_EXC_REVERSAL    = 16'h0000;
	localparam logic [15:0] RST_INH_REVERSAL    = 16'hB000;  // -20480
	localparam logic [15:0] RST_EXC_DECAY       = 16'd52429;
	localparam logic [15:0] RST_INH_DECAY       = 16'd58982;
	localparam logic [15:0] RST_SPIKE_THRESHOLD = 16'hCE00;  // -12800
	localparam logic [15:0] RST_RESET_POTENTIAL = 16'hC400;  // -15360

	// Configuration register set
	typedef struct packed {
		logic [15:0] leak_rate;
		logic [15:0] leak_reversal;
		logic [15:0] exc_reversal;
		logic [15:0] inh_reversal;
		logic [15:0] exc_decay;
		logic [15:0] inh_decay;
		logic [15:0] spike_threshold;
		logic [15:0] reset_potential;
	} cfg_t;

	// One word of the per-neuron state memory
	typedef struct packed {
		logic [15:0] potential;
		logic [15:0] exc;
		logic [15:0] inh;
		logic [15:0] stim;
	} nstate_t;

	// Outcome of one Euler step
	typedef struct packed {
		logic [15:0] potential;
		logic [15:0] exc;
		logic [15:0] inh;
		logic [7:0]  refr;
		logic        spike;
	} dp_out_t;

endpackage

[rtl/core/clif_cfg_regs.sv]
// Configuration register file with an APB-style slave port.
// Depends on clif_pkg (cfg_t, reg_idx_t, reset values).
module clif_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output clif_pkg::cfg_t      cfg
);
	import clif_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[4:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leak_rate       <= RST_LEAK_RATE;
			cfg_q.leak_reversal   <= RST_LEAK_REVERSAL;
			cfg_q.exc_reversal    <= RST_EXC_REVERSAL;
			cfg_q.inh_reversal    <= RST_INH_REVERSAL;
			cfg_q.exc_decay       <= RST_EXC_DECAY;
			cfg_q.inh_decay       <= RST_INH_DECAY;
			cfg_q.spike_threshold <= RST_SPIKE_THRESHOLD;
			cfg_q.reset_potential <= RST_RESET_POTENTIAL;
		end else if (wr_en) begin
			unique case (idx)
				REG_LEAK_RATE:       cfg_q.leak_rate       <= pwdata[15:0];
				REG_LEAK_REVERSAL:   cfg_q.leak_reversal   <= pwdata[15:0];
				REG_EXC_REVERSAL:    cfg_q.exc_reversal    <= pwdata[15:0];
				REG_INH_REVERSAL:    cfg_q.inh_reversal    <= pwdata[15:0];
				REG_EXC_DECAY:       cfg_q.exc_decay       <= pwdata[15:0];
				REG_INH_DECAY:       cfg_q.inh_decay       <= pwdata[15:0];
				REG_SPIKE_THRESHOLD: cfg_q.spike_threshold <= pwdata[15:0];
				REG_RESET_POTENTIAL: cfg_q.reset_potential <= pwdata[15:0];
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_LEAK_RATE:       prdata = {16'b0, cfg_q.leak_rate};
			REG_LEAK_REVERSAL:   prdata = {16'b0, cfg_q.leak_reversal};
			REG_EXC_REVERSAL:    prdata = {16'b0, cfg_q.exc_reversal};
			REG_INH_REVERSAL:    prdata = {16'b0, cfg_q.inh_reversal};
			REG_EXC_DECAY:       prdata = {16'b0, cfg_q.exc_decay};
			REG_INH_DECAY:       prdata = {16'b0, cfg_q.inh_decay};
			REG_SPIKE_THRESHOLD: prdata = {16'b0, cfg_q.spike_threshold};
			REG_RESET_POTENTIAL: prdata = {16'b0, cfg_q.reset_potential};
		endcase
	end

endmodule

[rtl/core/clif_state_mem.sv]
// Per-neuron state memories: potential/conductances/stimulus word and refractory count.
// Synchronous, one write and one read port each, registered read data. Depends on clif_pkg.
module clif_state_mem #(
	parameter int NEURONS = 1024,
	parameter int AW      = 10
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output clif_pkg::nstate_t   st_rdata,
	output logic [7:0]          ref_rdata,
	input  logic                st_we,
	input  logic [AW-1:0]       st_waddr,
	input  clif_pkg::nstate_t   st_wdata,
	input  logic                ref_we,
	input  logic [AW-1:0]       ref_waddr,
	input  logic [7:0]          ref_wdata
);
	import clif_pkg::*;

	nstate_t    st_mem  [NEURONS];
	logic [7:0] ref_mem [NEURONS];

	// State word memory
	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_waddr] <= st_wdata;
		end
		if (rd_en) begin
			st_rdata <= st_mem[rd_addr];
		end
	end

	// Refractory count memory
	always_ff @(posedge clk) begin
		if (ref_we) begin
			ref_mem[ref_waddr] <= ref_wdata;
		end
		if (rd_en) begin
			ref_rdata <= ref_mem[rd_addr];
		end
	end

endmodule

[rtl/core/clif_step_dp.sv]
// Euler step datapath: products, accumulate, round, saturate, spike and refractory.
// Two register stages (_s2 products, _s3 sum); final stage is combinational. Depends on clif_pkg.
module clif_step_dp #(
	parameter int REFRACTORY_STEPS = 20
) (
	input  logic                clk,
	input  clif_pkg::cfg_t      cfg,
	input  clif_pkg::nstate_t   st,
	input  logic [7:0]          ref_cnt,
	output clif_pkg::dp_out_t   res
);
	import clif_pkg::*;

	localparam logic [7:0] REF_LOAD = 8'(REFRACTORY_STEPS);

	logic signed [16:0] d_leak, d_exc, d_inh;
	logic signed [33:0] pl_s2, pe_s2, pi_s2;
	logic        [31:0] de_s2, di_s2;
	logic signed [35:0] stim_term;
	logic signed [35:0] acc_s3;
	logic        [32:0] ge_rnd, gi_rnd;
	logic        [15:0] ge_s3, gi_s3;
	logic signed [19:0] dv;
	logic signed [20:0] nv;
	logic        [15:0] v_sat;
	logic               spike;
	logic        [7:0]  ref0;

	// Differences to the reversal potentials, 17-bit signed
	always_comb begin
		d_leak = $signed({cfg.leak_reversal[15], cfg.leak_reversal})
			- $signed({st.potential[15], st.potential});
		d_exc  = $signed({cfg.exc_reversal[15], cfg.exc_reversal})
			- $signed({st.potential[15], st.potential});
		d_inh  = $signed({cfg.inh_reversal[15], cfg.inh_reversal})
			- $signed({st.potential[15], st.potential});
	end

	// Stage 2: one multiplier per term
	always_ff @(posedge clk) begin
		pl_s2 <= d_leak * $signed({1'b0, cfg.leak_rate});
		pe_s2 <= d_exc * $signed({1'b0, st.exc});
		pi_s2 <= d_inh * $signed({1'b0, st.inh});
		de_s2 <= st.exc * cfg.exc_decay;
		di_s2 <= st.inh * cfg.inh_decay;
	end

	assign stim_term = {{4{st.stim[15]}}, st.stim, 16'b0};
	assign ge_rnd    = {1'b0, de_s2} + 33'd32768;
	assign gi_rnd    = {1'b0, di_s2} + 33'd32768;

	// Stage 3: sum with rounding bias, decayed conductances
	always_ff @(posedge clk) begin
		acc_s3 <= pl_s2 + pe_s2 + pi_s2 + stim_term + 36'sd32768;
		ge_s3  <= ge_rnd[31:16];
		gi_s3  <= gi_rnd[31:16];
	end

	// Final: shift, integrate, saturate, threshold, refractory hold
	always_comb begin
		dv = acc_s3[35:16];
		nv = $signed({{5{st.potential[15]}}, st.potential}) + $signed({dv[19], dv});
		if (nv > 21'sd32767) begin
			v_sat = 16'h7FFF;
		end else if (nv < -21'sd32768) begin
			v_sat = 16'h8000;
		end else begin
			v_sat = nv[15:0];
		end
		spike = $signed(v_sat) > $signed(cfg.spike_threshold);
		ref0  = spike ? REF_LOAD : ref_cnt;

		res.exc   = ge_s3;
		res.inh   = gi_s3;
		res.spike = spike;
		if (ref0 != 8'd0) begin
			res.refr      = ref0 - 8'd1;
			res.potential = cfg.reset_potential;
		end else begin
			res.refr      = ref0;
			res.potential = spike ? cfg.reset_potential : v_sat;
		end
	end

endmodule

[rtl/core/conductance_lif_neuron_update.sv]
// Top level of the conductance LIF neuron update block: control FSM and result port.
// Depends on clif_pkg, clif_cfg_regs, clif_state_mem and clif_step_dp.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------------
//  command   | start / busy               | operation, neuron, load_potential,
//            |                            | load_exc, load_inh, load_stim
//  result    | done (one-cycle strobe)    | neuron_out, spiked, potential_out
//  config    | psel, penable, pwrite,     | paddr, pwdata, prdata
//            | pready (always high)       |
//
// After reset a sweep zeroes every entry of the refractory memory, with busy high.
// A load, or any command to a neuron index >= NEURONS, is registered at the accepting
// edge: done follows that edge and busy stays low. A step runs memory read, multiply,
// sum, then write-back with done; busy is high until the write-back edge, set by the
// read-modify-write of the state memory. Results cannot be stalled by the receiver.
module conductance_lif_neuron_update #(
	parameter int NEURONS          = 1024,
	parameter int REFRACTORY_STEPS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	// command
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [9:0]  neuron,
	input  logic [15:0] load_potential,
	input  logic [15:0] load_exc,
	input  logic [15:0] load_inh,
	input  logic [15:0] load_stim,
	// result
	output logic        done,
	output logic [9:0]  neuron_out,
	output logic        spiked,
	output logic [15:0] potential_out,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import clif_pkg::*;

	localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_FIN
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   clr_cnt_q;
	logic [AW-1:0]   addr_q;
	logic            done_q;
	logic [9:0]      neuron_q;
	logic            spiked_q;
	logic [15:0]     potential_q;

	cfg_t            cfg;
	nstate_t         st_rdata;
	logic [7:0]      ref_rdata;
	dp_out_t         dp;

	logic            accept;
	logic            in_range;
	logic [AW-1:0]   in_addr;
	logic            clr_last;
	logic            rd_en;
	logic            st_we;
	logic [AW-1:0]   st_waddr;
	nstate_t         st_wdata;
	logic            ref_we;
	logic [AW-1:0]   ref_waddr;
	logic [7:0]      ref_wdata;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign in_range = (32'(neuron) < 32'(NEURONS));
	assign in_addr  = AW'(neuron);
	assign clr_last = (clr_cnt_q == AW'(NEURONS - 1));
	assign pready   = 1'b1;

	assign done          = done_q;
	assign neuron_out    = neuron_q;
	assign spiked        = spiked_q;
	assign potential_out = potential_q;

	// Configuration registers
	clif_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Memory port control
	always_comb begin
		rd_en     = accept && (operation == OP_STEP) && in_range;
		st_we     = (accept && (operation == OP_LOAD) && in_range) || (state_q == ST_FIN);
		ref_we    = (state_q == ST_CLEAR) || (state_q == ST_FIN);
		if (state_q == ST_FIN) begin
			st_waddr           = addr_q;
			st_wdata.potential = dp.potential;
			st_wdata.exc       = dp.exc;
			st_wdata.inh       = dp.inh;
			st_wdata.stim      = st_rdata.stim;
		end else begin
			st_waddr           = in_addr;
			st_wdata.potential = load_potential;
			st_wdata.exc       = load_exc;
			st_wdata.inh       = load_inh;
			st_wdata.stim      = load_stim;
		end
		if (state_q == ST_CLEAR) begin
			ref_waddr = clr_cnt_q;
			ref_wdata = 8'd0;
		end else begin
			ref_waddr = addr_q;
			ref_wdata = dp.refr;
		end
	end

	clif_state_mem #(
		.NEURONS (NEURONS),
		.AW      (AW)
	) u_mem (
		.clk       (clk),
		.rd_en     (rd_en),
		.rd_addr   (in_addr),
		.st_rdata  (st_rdata),
		.ref_rdata (ref_rdata),
		.st_we     (st_we),
		.st_waddr  (st_waddr),
		.st_wdata  (st_wdata),
		.ref_we    (ref_we),
		.ref_waddr (ref_waddr),
		.ref_wdata (ref_wdata)
	);

	// Step arithmetic; read data holds while the step is in flight
	clif_step_dp #(
		.REFRACTORY_STEPS (REFRACTORY_STEPS)
	) u_dp (
		.clk     (clk),
		.cfg     (cfg),
		.st      (st_rdata),
		.ref_cnt (ref_rdata),
		.res     (dp)
	);

	// Control FSM and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			addr_q      <= '0;
			done_q      <= 1'b0;
			neuron_q    <= '0;
			spiked_q    <= 1'b0;
			potential_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						neuron_q <= neuron;
						addr_q   <= in_addr;
						if ((operation == OP_STEP) && in_range) begin
							state_q <= ST_MUL;
						end else begin
							done_q      <= 1'b1;
							spiked_q    <= 1'b0;
							potential_q <= in_range ? load_potential : 16'd0;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					done_q      <= 1'b1;
					spiked_q    <= dp.spike;
					potential_q <= dp.potential;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// A result only follows an accepted command or a step write-back
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(accept) || $past(state_q == ST_FIN)))
		else $error("result strobe without a source transaction");

	// Write-back always produces a result and frees the block
	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> (done && (state_q == ST_IDLE)))
		else $error("step write-back did not deliver a result");

	// An in-range step enters the pipeline without a result that cycle
	a_step_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (operation == OP_STEP) && in_range) |=> ((state_q == ST_MUL) && !done))
		else $error("step transaction did not start the pipeline");

	// No result while the refractory sweep runs
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !done)
		else $error("result during refractory clear");
`endif

endmodule
